>>> rtl/kmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmg_pkg
// Shared types and constants of the k-medoid marginal gain engine.
// ----------------------------------------------------------------------------
package kmg_pkg;

    // Defaults of the top level parameters
    localparam int MAX_POINTS_DEF = 1024;
    localparam int DIST_BITS_DEF  = 32;

    // Fixed field widths
    localparam int CFG_W     = 11;
    localparam int IDX_W     = 10;
    localparam int DIST_IN_W = 32;
    localparam int GAIN_W    = 48;
    localparam int TOTAL_W   = 56;
    localparam int COUNT_W   = 11;
    localparam int COUNT_MAX = 1024;

    localparam int NUM_POINTS_RST = 1024;

    // Stream word widths (padded to whole bytes)
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 120;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    // Result queue
    localparam int QDEPTH = 8;
    localparam int QPTR_W = 3;
    localparam int QOCC_W = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_COMMIT = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_CAND   = 2'd1,
        ST_NOT_LOADED = 2'd2
    } status_t;

    // Table stage to accumulator
    typedef struct packed {
        logic              valid;
        logic              last;
        mode_t             mode;
        status_t           status;
        logic [GAIN_W-1:0] add;
    } tbl_item_t;

    // One result word
    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } result_t;

endpackage

>>> rtl/kmg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kmg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/kmg_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmg_table
// Best-distance table: read on accept, read-modify-write in the next cycle,
// with a one-deep bypass for back-to-back hits on the same point.
// ----------------------------------------------------------------------------
module kmg_table #(
    parameter int MAX_POINTS = kmg_pkg::MAX_POINTS_DEF,
    parameter int DIST_BITS  = kmg_pkg::DIST_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_accept,
    input  kmg_pkg::mode_t                 in_mode,
    input  logic [kmg_pkg::IDX_W-1:0]      in_cand,
    input  logic [kmg_pkg::IDX_W-1:0]      in_point,
    input  logic [kmg_pkg::DIST_IN_W-1:0]  in_dist,
    input  logic                           in_last,
    input  logic [kmg_pkg::CFG_W-1:0]      num_points,
    output kmg_pkg::tbl_item_t             item,
    output logic                           pend
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int DW = DIST_BITS;

    // Stage 1 registers
    logic                      s1_valid_reg;
    logic                      s1_last_reg;
    kmg_pkg::mode_t            s1_mode_reg;
    logic [kmg_pkg::IDX_W-1:0] s1_cand_reg;
    logic [kmg_pkg::IDX_W-1:0] s1_point_reg;
    logic [DW-1:0]             s1_dist_reg;

    logic loaded_reg, loaded_next;

    // Bypass of the write done in the previous cycle
    logic          byp_valid_reg;
    logic [AW-1:0] byp_addr_reg;
    logic [DW-1:0] byp_data_reg;

    kmg_pkg::tbl_item_t item_reg, item_next;

    logic            we;
    logic [DW-1:0]   wdata;
    logic [AW-1:0]   pt_addr;
    logic [DW-1:0]   rdata;
    logic [DW-1:0]   best;
    logic [DW-1:0]   add;
    logic            pt_ok, cand_ok;
    kmg_pkg::status_t status;

    kmg_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_POINTS)
    ) u_best_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (pt_addr),
        .wdata (wdata),
        .re    (in_accept),
        .raddr (AW'(in_point)),
        .rdata (rdata)
    );

    // Capture the accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_accept;
        end
        if (in_accept) begin
            s1_last_reg  <= in_last;
            s1_mode_reg  <= in_mode;
            s1_cand_reg  <= in_cand;
            s1_point_reg <= in_point;
            s1_dist_reg  <= DW'(in_dist);
        end
    end

    // Range checks against the configured and built-in limits
    assign pt_ok   = ({1'b0, s1_point_reg} < num_points)
                     && (32'(s1_point_reg) < 32'(MAX_POINTS));
    assign cand_ok = ({1'b0, s1_cand_reg} < num_points)
                     && (32'(s1_cand_reg) < 32'(MAX_POINTS));
    assign pt_addr = AW'(s1_point_reg);
    assign best    = (byp_valid_reg && (byp_addr_reg == pt_addr)) ? byp_data_reg : rdata;

    // Table update and per-point gain
    always_comb begin
        we          = 1'b0;
        wdata       = s1_dist_reg;
        add         = '0;
        status      = kmg_pkg::ST_OK;
        loaded_next = loaded_reg;
        if (s1_valid_reg) begin
            unique case (s1_mode_reg) inside
                kmg_pkg::MODE_LOAD: begin
                    we = pt_ok;
                    if (s1_last_reg) begin
                        loaded_next = 1'b1;
                    end
                end
                kmg_pkg::MODE_CLEAR: begin
                    loaded_next = 1'b0;
                end
                kmg_pkg::MODE_QUERY, kmg_pkg::MODE_COMMIT: begin
                    if (pt_ok && cand_ok && loaded_reg) begin
                        if (s1_point_reg == s1_cand_reg) begin
                            // candidate's own point joins the selection
                            add   = best;
                            we    = (s1_mode_reg == kmg_pkg::MODE_COMMIT);
                            wdata = '0;
                        end else if (best > s1_dist_reg) begin
                            add = best - s1_dist_reg;
                            we  = (s1_mode_reg == kmg_pkg::MODE_COMMIT);
                        end
                    end
                    if (!cand_ok) begin
                        status = kmg_pkg::ST_BAD_CAND;
                    end else if (!loaded_reg) begin
                        status = kmg_pkg::ST_NOT_LOADED;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        item_next        = item_reg;
        item_next.valid  = s1_valid_reg;
        item_next.last   = s1_last_reg;
        item_next.mode   = s1_mode_reg;
        item_next.status = status;
        item_next.add    = kmg_pkg::GAIN_W'(add);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg    <= 1'b0;
            byp_valid_reg <= 1'b0;
            item_reg      <= '0;
        end else begin
            loaded_reg    <= loaded_next;
            byp_valid_reg <= we;
            item_reg      <= item_next;
        end
        byp_addr_reg <= pt_addr;
        byp_data_reg <= wdata;
    end

    assign item = item_reg;
    assign pend = s1_valid_reg && s1_last_reg;

endmodule

>>> rtl/kmg_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmg_accum
// Pass gain accumulation, then running total and selection count; emits
// one result word per last item.
// ----------------------------------------------------------------------------
module kmg_accum (
    input  logic                aclk,
    input  logic                aresetn,
    input  kmg_pkg::tbl_item_t  item,
    output logic                push,
    output kmg_pkg::result_t    result,
    output logic                pend
);

    localparam int GW = kmg_pkg::GAIN_W;
    localparam int TW = kmg_pkg::TOTAL_W;
    localparam int CW = kmg_pkg::COUNT_W;

    logic [GW-1:0] pass_reg, pass_next;
    logic [GW:0]   pass_sum;
    logic [GW-1:0] pass_upd;
    logic [GW-1:0] gain;

    logic             s3_valid_reg;
    logic             s3_last_reg;
    kmg_pkg::mode_t   s3_mode_reg;
    kmg_pkg::status_t s3_status_reg;
    logic [GW-1:0]    s3_gain_reg;

    logic [TW-1:0] total_reg, total_next;
    logic [TW:0]   total_sum;
    logic [CW-1:0] count_reg, count_next;

    // Saturating pass sum
    assign pass_sum = {1'b0, pass_reg} + {1'b0, item.add};
    assign pass_upd = pass_sum[GW] ? '1 : pass_sum[GW-1:0];

    always_comb begin
        pass_next = pass_reg;
        gain      = '0;
        if (item.valid) begin
            pass_next = (item.last || item.mode == kmg_pkg::MODE_CLEAR) ? '0 : pass_upd;
            if (item.status == kmg_pkg::ST_OK
                && (item.mode == kmg_pkg::MODE_QUERY || item.mode == kmg_pkg::MODE_COMMIT)) begin
                gain = pass_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_reg     <= '0;
            s3_valid_reg <= 1'b0;
        end else begin
            pass_reg     <= pass_next;
            s3_valid_reg <= item.valid;
        end
        s3_last_reg   <= item.last;
        s3_mode_reg   <= item.mode;
        s3_status_reg <= item.status;
        s3_gain_reg   <= gain;
    end

    // Running total and count
    assign total_sum = {1'b0, total_reg} + (TW + 1)'(s3_gain_reg);

    always_comb begin
        total_next = total_reg;
        count_next = count_reg;
        if (s3_valid_reg) begin
            if (s3_mode_reg == kmg_pkg::MODE_CLEAR) begin
                total_next = '0;
                count_next = '0;
            end else if (s3_mode_reg == kmg_pkg::MODE_COMMIT && s3_last_reg
                         && s3_status_reg == kmg_pkg::ST_OK) begin
                total_next = total_sum[TW] ? '1 : total_sum[TW-1:0];
                if (count_reg < CW'(kmg_pkg::COUNT_MAX)) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            count_reg <= '0;
        end else begin
            total_reg <= total_next;
            count_reg <= count_next;
        end
    end

    assign push          = s3_valid_reg && s3_last_reg;
    assign pend          = push;
    assign result.gain   = s3_gain_reg;
    assign result.total  = total_next;
    assign result.count  = count_next;
    assign result.status = s3_status_reg;

endmodule

>>> rtl/kmg_rqueue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmg_rqueue
// Small result queue in flops that decouples the output handshake.
// ----------------------------------------------------------------------------
module kmg_rqueue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  kmg_pkg::result_t            wdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output kmg_pkg::result_t            rdata,
    output logic [kmg_pkg::QOCC_W-1:0]  occ
);

    kmg_pkg::result_t            mem_reg [kmg_pkg::QDEPTH];
    logic [kmg_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [kmg_pkg::QOCC_W-1:0]  occ_reg, occ_next;
    logic                        pop;

    assign out_valid = (occ_reg != '0);
    assign pop       = out_valid && out_ready;

    always_comb begin
        occ_next = occ_reg;
        if (push && !pop) begin
            occ_next = occ_reg + 1'b1;
        end else if (pop && !push) begin
            occ_next = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end else begin
            occ_reg <= occ_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rd_ptr_reg];
    assign occ   = occ_reg;

endmodule

>>> rtl/kmedoid_marginal_gain_engine_top.sv
`timescale 1ns / 1ps
// Result path: the last word passes the stage 1, table item, stage 3 and result queue registers.
// Throughput: one word per cycle while s_tready is high; the best-distance RAM has one read and one write port.
// s_tready drops only while queued plus in-flight results fill the 8-entry result queue.
// Reset (aresetn low, synchronous): pipeline, queue, totals, count and loaded mark clear,
// num_points returns to 1024; the table itself is not cleared and needs a load pass.
// ----------------------------------------------------------------------------
// kmedoid_marginal_gain_engine_top
// Greedy k-medoid marginal gain engine: best-distance table, pass gain and totals.
// ----------------------------------------------------------------------------
module kmedoid_marginal_gain_engine_top #(
    parameter int MAX_POINTS = kmg_pkg::MAX_POINTS_DEF,
    parameter int DIST_BITS  = kmg_pkg::DIST_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kmg_pkg::S_TDATA_W-1:0]   s_tdata,  // candidate, point, distance, pad
    input  logic [kmg_pkg::MODE_W-1:0]      s_tuser,  // mode
    input  logic                            s_tlast,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kmg_pkg::M_TDATA_W-1:0]   m_tdata,  // gain, total_gain, selected_count, pad
    output logic [kmg_pkg::STATUS_W-1:0]    m_tuser,  // status
    // configuration: num_points
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kmg_pkg::CFG_W-1:0]       cfg_data
);

    logic [kmg_pkg::CFG_W-1:0]  num_points_reg;
    logic                       in_accept;
    kmg_pkg::tbl_item_t         tbl_item;
    logic                       tbl_pend, acc_pend;
    logic                       res_push;
    kmg_pkg::result_t           res_word, out_word;
    logic [kmg_pkg::QOCC_W-1:0] q_occ;
    logic [kmg_pkg::QOCC_W:0]   reserved;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= kmg_pkg::CFG_W'(kmg_pkg::NUM_POINTS_RST);
        end else if (cfg_valid && cfg_ready) begin
            num_points_reg <= cfg_data;
        end
    end

    // Accept while every result in flight still has a queue slot
    assign reserved = (kmg_pkg::QOCC_W + 1)'(q_occ)
                      + (kmg_pkg::QOCC_W + 1)'(tbl_pend)
                      + (kmg_pkg::QOCC_W + 1)'(tbl_item.valid && tbl_item.last)
                      + (kmg_pkg::QOCC_W + 1)'(acc_pend);
    assign s_tready  = (reserved < (kmg_pkg::QOCC_W + 1)'(kmg_pkg::QDEPTH));
    assign in_accept = s_tvalid && s_tready;

    kmg_table #(
        .MAX_POINTS (MAX_POINTS),
        .DIST_BITS  (DIST_BITS)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_mode    (kmg_pkg::mode_t'(s_tuser)),
        .in_cand    (s_tdata[9:0]),
        .in_point   (s_tdata[19:10]),
        .in_dist    (s_tdata[51:20]),
        .in_last    (s_tlast),
        .num_points (num_points_reg),
        .item       (tbl_item),
        .pend       (tbl_pend)
    );

    kmg_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (tbl_item),
        .push    (res_push),
        .result  (res_word),
        .pend    (acc_pend)
    );

    kmg_rqueue u_rqueue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .wdata     (res_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .rdata     (out_word),
        .occ       (q_occ)
    );

    // Result word packing
    assign m_tdata = {5'b0, out_word.count, out_word.total, out_word.gain};
    assign m_tuser = out_word.status;

    // No result is pushed into a full queue unless a word pops in the same cycle
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> (q_occ < kmg_pkg::QOCC_W'(kmg_pkg::QDEPTH)) || (m_tvalid && m_tready))
        else $error("result queue overflow");

    // Input is held off once all queue slots are spoken for
    a_reserve: assert property (@(posedge aclk) disable iff (!aresetn)
        (reserved >= (kmg_pkg::QOCC_W + 1)'(kmg_pkg::QDEPTH)) |-> !s_tready)
        else $error("input accepted without a free result slot");

    // A result only appears after a push
    a_valid_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(res_push))
        else $error("result word appeared without a push");

endmodule

>>> dv/kmg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmg_checker
// Watches the input, result and configuration channels of the marginal gain
// engine. It keeps its own copy of the best-distance table, the pass gain,
// the running totals and num_points, predicts one result word per accepted
// last word, and compares each result word field by field in order.
// ----------------------------------------------------------------------------
module kmg_checker #(
    parameter int MAX_POINTS = kmg_pkg::MAX_POINTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [kmg_pkg::S_TDATA_W-1:0] s_tdata,    // candidate, point, distance, pad
    input  logic [kmg_pkg::MODE_W-1:0]    s_tuser,    // mode
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [kmg_pkg::M_TDATA_W-1:0] m_tdata,    // gain, total_gain, selected_count, pad
    input  logic [kmg_pkg::STATUS_W-1:0]  m_tuser,    // status
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [kmg_pkg::CFG_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            pending,
    output int                            results_checked
);

    localparam int MAX_PRINT = 30;
    localparam int GW        = kmg_pkg::GAIN_W;
    localparam int TW        = kmg_pkg::TOTAL_W;
    localparam int CW        = kmg_pkg::COUNT_W;
    localparam int IW        = kmg_pkg::IDX_W;

    // Predicted engine state
    logic [kmg_pkg::DIST_IN_W-1:0] best_dist [MAX_POINTS];
    logic                          table_loaded;
    logic [GW-1:0]                 pass_gain;
    logic [TW-1:0]                 total_gain;
    logic [CW-1:0]                 sel_count;
    logic [kmg_pkg::CFG_W-1:0]     num_points;

    kmg_pkg::result_t expected_results[$];
    int               err_cnt;
    int               checked_cnt;

    function automatic int point_limit();
        return (int'(num_points) < MAX_POINTS) ? int'(num_points) : MAX_POINTS;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (err_cnt < MAX_PRINT)
            $display("[%0t] mismatch, %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        err_cnt++;
    endtask

    // Apply one accepted input word; queue a result word on last
    task automatic apply_word(input kmg_pkg::mode_t md, input logic [IW-1:0] cand,
                              input logic [IW-1:0] pt,
                              input logic [kmg_pkg::DIST_IN_W-1:0] dist_val,
                              input logic last);
        int                 lim;
        logic               pt_ok;
        logic               cand_ok;
        kmg_pkg::status_t   st;
        logic [GW-1:0]      add;
        logic [GW-1:0]      gain_out;
        logic [GW:0]        gsum;
        logic [TW:0]        tsum;
        kmg_pkg::result_t   r;

        lim      = point_limit();
        pt_ok    = int'(pt) < lim;
        cand_ok  = int'(cand) < lim;
        st       = kmg_pkg::ST_OK;
        gain_out = '0;

        case (md)
            kmg_pkg::MODE_LOAD: begin
                if (pt_ok)
                    best_dist[pt] = dist_val;
                if (last)
                    table_loaded = 1'b1;
            end
            kmg_pkg::MODE_CLEAR: begin
                total_gain   = '0;
                sel_count    = '0;
                table_loaded = 1'b0;
                pass_gain    = '0;
            end
            default: begin
                // invalid words add nothing and leave the table alone
                if (pt_ok && cand_ok && table_loaded) begin
                    add = '0;
                    if (pt == cand) begin
                        add = GW'(best_dist[pt]);
                        if (md == kmg_pkg::MODE_COMMIT)
                            best_dist[pt] = '0;
                    end else if (best_dist[pt] > dist_val) begin
                        add = GW'(best_dist[pt] - dist_val);
                        if (md == kmg_pkg::MODE_COMMIT)
                            best_dist[pt] = dist_val;
                    end
                    gsum      = {1'b0, pass_gain} + {1'b0, add};
                    pass_gain = gsum[GW] ? '1 : gsum[GW-1:0];
                end
                if (last) begin
                    // bad candidate wins over an unloaded table
                    if (!cand_ok)
                        st = kmg_pkg::ST_BAD_CAND;
                    else if (!table_loaded)
                        st = kmg_pkg::ST_NOT_LOADED;
                    if (st == kmg_pkg::ST_OK) begin
                        gain_out = pass_gain;
                        if (md == kmg_pkg::MODE_COMMIT) begin
                            tsum       = {1'b0, total_gain} + (TW + 1)'(pass_gain);
                            total_gain = tsum[TW] ? '1 : tsum[TW-1:0];
                            if (sel_count < CW'(kmg_pkg::COUNT_MAX))
                                sel_count = sel_count + 1'b1;
                        end
                    end
                end
            end
        endcase

        if (last) begin
            r.gain   = gain_out;
            r.total  = total_gain;
            r.count  = sel_count;
            r.status = st;
            expected_results.insert(expected_results.size(), r);
            pass_gain = '0;
        end
    endtask

    // Channel monitor
    always @(posedge aclk) begin
        kmg_pkg::result_t want;
        if (!aresetn) begin
            table_loaded = 1'b0;
            pass_gain    = '0;
            total_gain   = '0;
            sel_count    = '0;
            num_points   = kmg_pkg::CFG_W'(kmg_pkg::NUM_POINTS_RST);
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing expected", '0, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata[GW-1:0] !== want.gain)
                        report_mismatch("gain", 64'(want.gain), 64'(m_tdata[GW-1:0]));
                    if (m_tdata[GW +: TW] !== want.total)
                        report_mismatch("total_gain", 64'(want.total),
                                        64'(m_tdata[GW +: TW]));
                    if (m_tdata[GW+TW +: CW] !== want.count)
                        report_mismatch("selected_count", 64'(want.count),
                                        64'(m_tdata[GW+TW +: CW]));
                    if (m_tuser !== want.status)
                        report_mismatch("status", 64'(want.status), 64'(m_tuser));
                    checked_cnt++;
                end
            end
            if (cfg_valid && cfg_ready)
                num_points = cfg_data;
            if (s_tvalid && s_tready)
                apply_word(kmg_pkg::mode_t'(s_tuser), s_tdata[IW-1:0], s_tdata[IW +: IW],
                           s_tdata[2*IW +: kmg_pkg::DIST_IN_W], s_tlast);
        end
        mismatches      <= err_cnt;
        pending         <= expected_results.size();
        results_checked <= checked_cnt;
    end

endmodule

>>> dv/kmedoid_marginal_gain_engine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmedoid_marginal_gain_engine_top_test
// Drives load, query, commit and clear passes into the marginal gain engine
// under several num_points settings, with random idle bursts on both channels,
// a long result stall and a run of commits that saturates the selection
// count. The checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
module kmedoid_marginal_gain_engine_top_test;

    typedef logic [kmg_pkg::IDX_W-1:0]     idx_t;
    typedef logic [kmg_pkg::DIST_IN_W-1:0] dist_t;

    localparam int DRAIN_CYCLES   = 10;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int TIMEOUT_NS     = 1_000_000;
    localparam int NPTS           = kmg_pkg::MAX_POINTS_DEF;
    localparam int CW             = kmg_pkg::CFG_W;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [kmg_pkg::S_TDATA_W-1:0] s_tdata   = '0;   // candidate, point, distance, pad
    logic [kmg_pkg::MODE_W-1:0]    s_tuser   = '0;   // mode
    logic                          s_tlast   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [kmg_pkg::M_TDATA_W-1:0] m_tdata;          // gain, total_gain, selected_count, pad
    logic [kmg_pkg::STATUS_W-1:0]  m_tuser;          // status
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CW-1:0]                 cfg_data  = '0;

    int mismatches;
    int pending;
    int results_checked;

    // Stimulus-side view of the table, so no unwritten entry is ever read
    bit         written [NPTS];
    idx_t       written_list[$];
    bit         loaded_view  = 1'b0;
    logic [CW-1:0] np_cur = CW'(kmg_pkg::NUM_POINTS_RST);

    int words_sent  = 0;
    int cfg_writes  = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_reqs   = 0;

    kmedoid_marginal_gain_engine_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    kmg_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_checked(results_checked)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d result words outstanding", pending);
        $display("simulation failed");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off on request
    initial begin : rx_side
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge aclk);
            if (hold_reqs != holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (rx_idle_pct != 0 && $urandom_range(1, 100) <= rx_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic int cur_limit();
        return (int'(np_cur) < NPTS) ? int'(np_cur) : NPTS;
    endfunction

    function automatic dist_t rand_dist();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return kmg_pkg::DIST_IN_W'($urandom_range(0, 255));
            3:       return kmg_pkg::DIST_IN_W'($urandom_range(0, 65535));
            default: return kmg_pkg::DIST_IN_W'($urandom);
        endcase
    endfunction

    // Random point that never reads an unwritten entry
    function automatic idx_t pick_point();
        idx_t p;
        if ($urandom_range(0, 1) != 0)
            p = idx_t'($urandom_range(0, cur_limit() - 1));
        else
            p = idx_t'($urandom_range(0, NPTS - 1));
        if (!loaded_view || int'(p) >= cur_limit() || written[p] || written_list.size() == 0)
            return p;
        return written_list[$urandom_range(0, written_list.size() - 1)];
    endfunction

    task automatic shuffle_points(ref idx_t pts[$]);
        idx_t tmp;
        int   j;
        for (int i = pts.size() - 1; i > 0; i--) begin
            j      = $urandom_range(0, i);
            tmp    = pts[i];
            pts[i] = pts[j];
            pts[j] = tmp;
        end
    endtask

    // Offer one input word and wait for it to be taken
    task automatic send_word(input kmg_pkg::mode_t md, input idx_t cand, input idx_t pt,
                             input dist_t dist_val, input logic last);
        if (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, dist_val, pt, cand};
        s_tuser  <= md;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
        if (md == kmg_pkg::MODE_LOAD) begin
            if (int'(pt) < cur_limit() && !written[pt]) begin
                written[pt] = 1'b1;
                written_list.insert(written_list.size(), pt);
            end
            if (last)
                loaded_view = 1'b1;
        end else if (md == kmg_pkg::MODE_CLEAR) begin
            loaded_view = 1'b0;
        end
    endtask

    task automatic issue_pass(input kmg_pkg::mode_t md, input idx_t cand, ref idx_t pts[$]);
        for (int i = 0; i < pts.size(); i++)
            send_word(md, cand, pts[i], rand_dist(), i == pts.size() - 1);
    endtask

    // Wait until every result is back and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_num_points(input logic [CW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        np_cur = v;
        cfg_writes++;
    endtask

    // Full shuffled load for small tables, a random subset for large ones
    task automatic load_pass();
        idx_t pts[$];
        int   lim;
        lim = cur_limit();
        if (lim <= 64) begin
            for (int p = 0; p < lim; p++)
                pts.insert(pts.size(), idx_t'(p));
            shuffle_points(pts);
        end else begin
            repeat (24) pts.insert(pts.size(), idx_t'($urandom_range(0, lim - 1)));
        end
        // stray out-of-range word, ignored by the table
        if (lim < NPTS && $urandom_range(0, 3) == 0)
            pts.push_front(idx_t'($urandom_range(lim, NPTS - 1)));
        issue_pass(kmg_pkg::MODE_LOAD, idx_t'($urandom_range(0, NPTS - 1)), pts);
    endtask

    // Query or commit pass over the written points in range, sometimes with a bad candidate
    task automatic gain_pass(input kmg_pkg::mode_t md);
        idx_t pts[$];
        idx_t cand;
        int   lim;
        lim = cur_limit();
        foreach (written_list[k])
            if (int'(written_list[k]) < lim)
                pts.insert(pts.size(), written_list[k]);
        shuffle_points(pts);
        if (lim < NPTS && $urandom_range(0, 7) == 0)
            cand = idx_t'($urandom_range(lim, NPTS - 1));
        else
            cand = pts[$urandom_range(0, pts.size() - 1)];
        issue_pass(md, cand, pts);
    endtask

    // Short pass of mixed modes and random fields
    task automatic ragged_pass();
        int             len;
        kmg_pkg::mode_t md;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0:          md = kmg_pkg::MODE_LOAD;
                1:          md = kmg_pkg::MODE_CLEAR;
                2, 3, 4, 5: md = kmg_pkg::MODE_QUERY;
                default:    md = kmg_pkg::MODE_COMMIT;
            endcase
            send_word(md, idx_t'($urandom_range(0, NPTS - 1)), pick_point(),
                      rand_dist(), i == len - 1);
        end
    endtask

    task automatic run_phase(input logic [CW-1:0] np, input int budget);
        int stop_at;
        int kind;
        drain();
        set_num_points(np);
        load_pass();
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind <= 5) begin
                gain_pass(($urandom_range(0, 1) != 0) ? kmg_pkg::MODE_COMMIT
                                                      : kmg_pkg::MODE_QUERY);
            end else if (kind == 6) begin
                ragged_pass();
            end else if (kind == 7) begin
                if ($urandom_range(0, 1) != 0)
                    send_word(kmg_pkg::MODE_CLEAR, pick_point(), pick_point(), rand_dist(),
                              1'b0);
                send_word(kmg_pkg::MODE_CLEAR, pick_point(), pick_point(), rand_dist(), 1'b1);
                if ($urandom_range(0, 1) != 0)
                    load_pass();
            end else begin
                load_pass();
            end
        end
    endtask

    // Main sequence
    initial begin : stimulus
        logic [CW-1:0] np_set [6];
        int            idle_set [3];

        np_set   = '{11'd3, 11'd1, 11'd2047, 11'd12, 11'd1024, 11'd40};
        idle_set = '{0, 10, 30};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: table not loaded, then clear
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_word(kmg_pkg::MODE_QUERY,  10'd5,   10'd5,    32'h0000_0000, 1'b1);
        send_word(kmg_pkg::MODE_COMMIT, 10'd0,   10'd1023, 32'hFFFF_FFFF, 1'b1);
        send_word(kmg_pkg::MODE_CLEAR,  10'h3FF, 10'h3FF,  32'hFFFF_FFFF, 1'b1);
        drain();
        set_num_points(11'd4);

        // Load with distance extremes and one out-of-range point
        send_word(kmg_pkg::MODE_LOAD, 10'd0, 10'd0,    32'h0000_0000, 1'b0);
        send_word(kmg_pkg::MODE_LOAD, 10'd0, 10'd3,    32'hFFFF_FFFF, 1'b0);
        send_word(kmg_pkg::MODE_LOAD, 10'd0, 10'd1,    32'h0001_0000, 1'b0);
        send_word(kmg_pkg::MODE_LOAD, 10'd0, 10'd1023, 32'h1234_5678, 1'b0);
        send_word(kmg_pkg::MODE_LOAD, 10'd0, 10'd2,    32'h8000_0000, 1'b1);

        // Query: candidate's own best plus lowered neighbors
        send_word(kmg_pkg::MODE_QUERY, 10'd1, 10'd0, 32'h0000_0005, 1'b0);
        send_word(kmg_pkg::MODE_QUERY, 10'd1, 10'd1, 32'hFFFF_FFFF, 1'b0);
        send_word(kmg_pkg::MODE_QUERY, 10'd1, 10'd2, 32'h7FFF_FFFF, 1'b0);
        send_word(kmg_pkg::MODE_QUERY, 10'd1, 10'd3, 32'h0000_0000, 1'b1);

        // Commit lowers the table and counts
        send_word(kmg_pkg::MODE_COMMIT, 10'd3, 10'd3, 32'h0000_1111, 1'b0);
        send_word(kmg_pkg::MODE_COMMIT, 10'd3, 10'd2, 32'h0000_0000, 1'b0);
        send_word(kmg_pkg::MODE_COMMIT, 10'd3, 10'd0, 32'h0000_0001, 1'b0);
        send_word(kmg_pkg::MODE_COMMIT, 10'd3, 10'd1, 32'hFFFF_FFFF, 1'b1);

        // Bad candidate, then a commit whose only point is out of range
        send_word(kmg_pkg::MODE_QUERY,  10'd1023, 10'd1,   32'h0000_0010, 1'b1);
        send_word(kmg_pkg::MODE_COMMIT, 10'd2,    10'd900, 32'h0000_0020, 1'b1);

        // Clear mid-pass, then a query on the unloaded table, then reload
        send_word(kmg_pkg::MODE_CLEAR, 10'd0, 10'd0, 32'h0, 1'b0);
        send_word(kmg_pkg::MODE_QUERY, 10'd0, 10'd0, 32'h0, 1'b1);
        send_word(kmg_pkg::MODE_LOAD,  10'd0, 10'd1, 32'h7, 1'b1);

        // Random phases over several table sizes
        for (int i = 0; i < 6; i++) begin
            tx_idle_pct = idle_set[$urandom_range(0, 2)];
            rx_idle_pct = idle_set[$urandom_range(0, 2)];
            run_phase(np_set[i], 60);
        end

        // Single-word commits until the selection count saturates
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        drain();
        set_num_points(11'd2);
        load_pass();
        send_word(kmg_pkg::MODE_CLEAR, 10'd0, 10'd0, rand_dist(), 1'b0);
        load_pass();
        repeat (1040)
            send_word(kmg_pkg::MODE_COMMIT, idx_t'($urandom_range(0, 1)), pick_point(),
                      rand_dist(), 1'b1);

        // Long result stall while words keep coming, so the input backs up
        drain();
        tx_idle_pct = 0;
        hold_reqs <= hold_reqs + 1;
        repeat (40)
            send_word(kmg_pkg::MODE_QUERY, idx_t'($urandom_range(0, 1)), pick_point(),
                      rand_dist(), 1'b1);

        // Last stretch without idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(CW'($urandom_range(1, 20)), 100);
        drain();

        $display("covered %0d input words under %0d num_points settings, %0d results checked",
                 words_sent, cfg_writes, results_checked);
        $display("included a %0d-cycle result stall and selection count saturation",
                 RX_HOLD_CYCLES);
        if (mismatches == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/kmg_pkg.sv
rtl/kmg_ram.sv
rtl/kmg_table.sv
rtl/kmg_accum.sv
rtl/kmg_rqueue.sv
rtl/kmedoid_marginal_gain_engine_top.sv
dv/kmg_checker.sv
dv/kmedoid_marginal_gain_engine_top_test.sv
